FILE: rtl/multipart_boundary_splitter_top_assert.svh
// ----------------------------------------------------------------------------
// multipart_boundary_splitter_top_assert.svh
// Assertion macros shared by the splitter RTL. All sample on clock and are
// quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef MULTIPART_BOUNDARY_SPLITTER_TOP_ASSERT_SVH
`define MULTIPART_BOUNDARY_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define MBS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Types, codes and helpers for the multipart boundary splitter.
// ----------------------------------------------------------------------------
package mbs_pkg;

   // Delimiter storage geometry
   localparam int MAX_DELIMITER = 64;
   localparam int DIDX_W        = $clog2(MAX_DELIMITER);
   localparam int LEN_W         = $clog2(MAX_DELIMITER + 1);

   // Line-end characters
   localparam logic [7:0] CHR_CR = 8'h0D;
   localparam logic [7:0] CHR_LF = 8'h0A;

   // Input opcodes
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_STREAM  = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_PART = 2'd1,
      KIND_MSG  = 2'd2
   } kind_type;

   // Parser phase
   typedef enum logic [2:0] {
      PH_FIRST_LINE = 3'd0,
      PH_HEADER     = 3'd1,
      PH_BODY       = 3'd2,
      PH_END_CR     = 3'd3,
      PH_END_LF     = 3'd4,
      PH_DONE       = 3'd5
   } phase_type;

   // Sequencer state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_RELEASE,
      ST_EMIT
   } seq_state_type;

   // One result handed from the sequencer to the output register
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } emit_type;

   // Delimiter length in use: zero acts as one, large values clamp
   function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] n;
      n = raw;
      if (n == '0) n = LEN_W'(1);
      if (n > LEN_W'(MAX_DELIMITER)) n = LEN_W'(MAX_DELIMITER);
      return n;
   endfunction

endpackage

FILE: rtl/multipart_boundary_splitter_top.sv
// ----------------------------------------------------------------------------
// multipart_boundary_splitter_top
// Splits a multipart body stream at a loadable CR LF + boundary delimiter.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_op req_byte_in  | in (stall out)
//          | req_delimiter_index                     |
//  rsp     | rsp_valid rsp_stall rsp_kind            | out (stall in)
//          | rsp_byte_out rsp_last                   |
//  csr     | csr_write_enable csr_write_data         | in
//
//  Load, restart and unused opcodes never make the block busy. A stream
//  byte is accepted, then compared against the registered delimiter RAM
//  read, and then emitted when it yields a single result. A mismatch at
//  match position p replays the p held prefix bytes, one per free output
//  slot, through the single RAM read port, and then passes on the current
//  byte as well unless it starts a new match. Result stalls hold the
//  replay and emit steps. Reset is synchronous and needs no clearing pass;
//  delimiter bytes hold undefined values until loaded.
// ----------------------------------------------------------------------------
module multipart_boundary_splitter_top
   import mbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_byte_in,
   input  logic [DIDX_W-1:0] req_delimiter_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_byte_out,
   output logic              rsp_last,
   input  logic              csr_write_enable,
   input  logic [LEN_W-1:0]  csr_write_data
);

`include "multipart_boundary_splitter_top_assert.svh"

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  used_len;
   logic              busy;
   logic              accept;
   logic              out_free;
   logic              ram_we;
   logic [DIDX_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   emit_type          emit;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // Input handshake
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign ram_we    = accept && (op_type'(req_op) == OP_LOAD);

   // Delimiter length register
   assign len_in   = csr_write_enable ? csr_write_data : len_ff;
   assign used_len = used_length(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else begin
         len_ff <= len_in;
      end
   end

   mbs_delim_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_delimiter_index),
      .wr_data (req_byte_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mbs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_op),
      .byte_in  (req_byte_in),
      .used_len (used_len),
      .rd_data  (rd_data),
      .out_free (out_free),
      .busy     (busy),
      .rd_addr  (rd_addr),
      .emit     (emit)
   );

   // Output register: takes a new transaction when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit.kind;
         rsp_byte_in  = emit.data;
         rsp_last_in  = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Assertions
   `MBS_ASSERT_SAME(a_emit_slot_free, emit.valid, out_free, "result emitted into a full slot")
   `MBS_ASSERT_NEXT(a_stream_goes_busy, accept && (op_type'(req_op) == OP_STREAM), req_stall, "stream byte did not start work")
   `MBS_ASSERT_SAME(a_len_range, 1'b1, (used_len != '0) && (used_len <= LEN_W'(MAX_DELIMITER)), "delimiter length out of range")

endmodule

FILE: rtl/mbs_delim_ram.sv
// ----------------------------------------------------------------------------
// mbs_delim_ram
// Delimiter byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbs_delim_ram
   import mbs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [DIDX_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [DIDX_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [MAX_DELIMITER];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mbs_seq.sv
// ----------------------------------------------------------------------------
// mbs_seq
// Parser sequencer: phase tracking, delimiter match position and the shared
// byte comparator that checks the held stream byte against the delimiter RAM.
// ----------------------------------------------------------------------------
module mbs_seq
   import mbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        op,
   input  logic [7:0]        byte_in,
   input  logic [LEN_W-1:0]  used_len,
   input  logic [7:0]        rd_data,
   input  logic              out_free,
   output logic              busy,
   output logic [DIDX_W-1:0] rd_addr,
   output emit_type          emit
);

   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [DIDX_W-1:0] mp_ff, mp_in;
   logic              lht_ff, lht_in;
   logic [7:0]        c_ff, c_in;
   logic [DIDX_W-1:0] pos_ff, pos_in;
   logic [DIDX_W-1:0] idx_ff, idx_in;
   logic              m0_ff, m0_in;
   kind_type          pend_ff, pend_in;

   logic [DIDX_W-1:0] p_eff;
   logic              eq;
   logic              full_pos;
   logic              body_part;
   logic              body_byte;
   logic              body_release;
   logic              rel_last;
   logic              m0;
   logic              cmp_res;
   kind_type          cmp_kind;

   // Match position clamped to the current length
   assign p_eff = ({1'b0, mp_ff} >= used_len) ? DIDX_W'(used_len - LEN_W'(1)) : mp_ff;

   // Shared comparator and body-phase decisions
   assign eq           = (rd_data == c_ff);
   assign full_pos     = (({1'b0, pos_ff} + LEN_W'(1)) >= used_len);
   assign body_part    = eq && full_pos;
   assign body_byte    = (pos_ff == '0) && !eq;
   assign body_release = (pos_ff != '0) && !eq;
   assign rel_last     = (idx_ff == (pos_ff - DIDX_W'(1)));
   assign m0           = (idx_ff == '0) ? eq : m0_ff;

   // Single-result decision for the compare step
   always_comb begin
      cmp_res  = 1'b0;
      cmp_kind = KIND_MSG;
      unique case (phase_ff)
         PH_BODY: begin
            cmp_res  = body_part || body_byte;
            cmp_kind = body_part ? KIND_PART : KIND_BYTE;
         end
         PH_END_CR: begin
            cmp_res = (c_ff != CHR_CR);
         end
         PH_END_LF: begin
            cmp_res = (c_ff != CHR_LF);
         end
         default: begin
            cmp_res = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (op_type'(op) == OP_STREAM)) state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((phase_ff == PH_BODY) && body_release) state_in = ST_RELEASE;
            else if (cmp_res)                          state_in = ST_EMIT;
            else                                       state_in = ST_IDLE;
         end
         ST_RELEASE: begin
            if (out_free && rel_last) state_in = m0 ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      phase_in = phase_ff;
      mp_in    = mp_ff;
      lht_in   = lht_ff;
      c_in     = c_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      m0_in    = m0_ff;
      pend_in  = pend_ff;
      rd_addr  = idx_ff;
      emit     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = p_eff;
            if (accept) begin
               c_in   = byte_in;
               pos_in = p_eff;
               if (op_type'(op) == OP_RESTART) begin
                  mp_in    = '0;
                  phase_in = PH_FIRST_LINE;
                  lht_in   = 1'b0;
               end
            end
         end
         ST_CMP: begin
            rd_addr = '0;
            idx_in  = '0;
            pend_in = cmp_kind;
            unique case (phase_ff)
               PH_FIRST_LINE: begin
                  if (c_ff == CHR_LF) begin
                     phase_in = PH_HEADER;
                     lht_in   = 1'b0;
                  end
               end
               PH_HEADER: begin
                  if (c_ff == CHR_LF) begin
                     if (!lht_ff) begin
                        phase_in = PH_BODY;
                        mp_in    = '0;
                     end
                     lht_in = 1'b0;
                  end else if (c_ff != CHR_CR) begin
                     lht_in = 1'b1;
                  end
               end
               PH_BODY: begin
                  if (body_part) begin
                     mp_in    = '0;
                     phase_in = PH_END_CR;
                  end else if (eq) begin
                     mp_in = pos_ff + DIDX_W'(1);
                  end else if (body_byte) begin
                     mp_in = '0;
                  end
               end
               PH_END_CR: begin
                  phase_in = (c_ff == CHR_CR) ? PH_END_LF : PH_DONE;
               end
               PH_END_LF: begin
                  if (c_ff == CHR_LF) begin
                     phase_in = PH_HEADER;
                     lht_in   = 1'b0;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
         ST_RELEASE: begin
            // replay held prefix bytes, one per free output slot
            rd_addr = out_free ? (idx_ff + DIDX_W'(1)) : idx_ff;
            if (idx_ff == '0) m0_in = eq;
            if (out_free) begin
               emit.valid = 1'b1;
               emit.kind  = KIND_BYTE;
               emit.data  = rd_data;
               emit.last  = rel_last && m0;
               idx_in     = idx_ff + DIDX_W'(1);
               if (rel_last) begin
                  mp_in   = m0 ? DIDX_W'(1) : '0;
                  pend_in = KIND_BYTE;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.kind  = pend_ff;
               emit.data  = (pend_ff == KIND_BYTE) ? c_ff : 8'h00;
               emit.last  = 1'b1;
            end
         end
         default: begin
            emit = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FIRST_LINE;
         mp_ff    <= '0;
         lht_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mp_ff    <= mp_in;
         lht_ff   <= lht_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      m0_ff   <= m0_in;
      pend_ff <= pend_in;
   end

endmodule
